>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 convolution block.
// Self-contained; included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, reset or not.
`define ICV_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define ICV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> design/icv_pkg.sv
// Shared constants, types and kernel coefficients of the 3x3 convolution block.
// No dependencies; compiled before all other files of the block.
package icv_pkg;

  parameter int DEF_MAX_WIDTH  = 1024;
  parameter int DEF_MAX_HEIGHT = 1024;
  parameter int DEF_PIXEL_BITS = 8;

  parameter int CFG_IDX_BITS  = 2;
  parameter int CFG_DATA_BITS = 11;
  parameter int SIZE_RESET    = 1024;

  parameter int VALUE_BITS = 13;
  parameter int POS_BITS   = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } icv_cfg_e;

  typedef enum logic [1:0] {
    K_EMBOSS  = 2'd0,
    K_EDGE    = 2'd1,
    K_SHARPEN = 2'd2,
    K_BLUR    = 2'd3
  } icv_kernel_e;

  // Coefficients indexed by kernel, window row (top first), window column (left first).
  localparam logic signed [3:0] KERNEL_COEF [4][3][3] = '{
    '{'{ 2, -1,  0}, '{-1,  1,  1}, '{ 0,  1,  2}},
    '{'{-1,  0,  1}, '{-2,  0,  2}, '{-1,  0,  1}},
    '{'{ 1, -2,  1}, '{-2,  5, -2}, '{ 1, -2,  1}},
    '{'{ 1,  1,  1}, '{ 1,  1,  1}, '{ 1,  1,  1}}
  };

  // Position and border information that travels with an output word.
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
    logic                interior;
  } icv_meta_t;

endpackage

>>> design/icv_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on icv_pkg for field widths and defaults.
interface icv_in_if import icv_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface icv_out_if import icv_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [POS_BITS-1:0]          out_row;
  logic [POS_BITS-1:0]          out_col;
  logic                         last;

  modport source (output valid, output value, output out_row, output out_col, output last,
                  input ready);
  modport sink   (input valid, input value, input out_row, input out_col, input last,
                  output ready);
endinterface

>>> design/icv_line_store.sv
// Two synchronous line memories (older row, recent row) with registered reads.
// Depends on icv_pkg for parameter defaults.
module icv_line_store import icv_pkg::*; #(
  parameter int DEPTH     = DEF_MAX_WIDTH,
  parameter int DATA_BITS = DEF_PIXEL_BITS,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [DATA_BITS-1:0] wr_older_i,
  input  logic [DATA_BITS-1:0] wr_recent_i,
  output logic [DATA_BITS-1:0] rd_older_o,
  output logic [DATA_BITS-1:0] rd_recent_o
);

  logic [DATA_BITS-1:0] older_mem  [DEPTH];
  logic [DATA_BITS-1:0] recent_mem [DEPTH];

  // Read returns the contents before a write to the same entry at the same edge.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_older_o  <= older_mem[rd_addr_i];
      rd_recent_o <= recent_mem[rd_addr_i];
    end
    if (wr_en_i) begin
      older_mem[wr_addr_i]  <= wr_older_i;
      recent_mem[wr_addr_i] <= wr_recent_i;
    end
  end

endmodule

>>> design/icv_kernel_mac.sv
// Weighted 3x3 sum for the selected preset kernel, or the center pixel at borders.
// Depends on icv_pkg for the coefficient table and result width.
module icv_kernel_mac import icv_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic [PIXEL_BITS-1:0]      win_i [3][3],
  input  icv_kernel_e                kernel_i,
  input  logic                       interior_i,
  output logic signed [VALUE_BITS-1:0] value_o
);

  localparam int SUMW = PIXEL_BITS + 5;

  logic signed [SUMW-1:0]            sums [4];
  logic signed [SUMW-1:0]            res;
  logic signed [SUMW+VALUE_BITS-1:0] res_ext;

  // Coefficients are constants after unrolling, so each product is a shift-add.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sums[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sums[k] = sums[k] + SUMW'(KERNEL_COEF[k][i][j]) * $signed(SUMW'(win_i[i][j]));
        end
      end
    end
  end

  always_comb begin
    if (interior_i) begin
      res = sums[kernel_i];
    end else begin
      res = $signed(SUMW'(win_i[1][1]));
    end
  end

  assign res_ext = {{VALUE_BITS{res[SUMW-1]}}, res};
  assign value_o = res_ext[VALUE_BITS-1:0];

endmodule

>>> design/image_convolution_3x3_unit.sv
// Top level of the streaming 3x3 convolution block.
// Depends on icv_pkg, icv_stream_if, icv_line_store, icv_kernel_mac and assert_macros.svh.
//
// Usage: pixels enter on in_i in raster order, one word per raster position. A word
// with mode high is a drain word carrying no pixel. After the width*height pixels of a
// frame the host sends width+1 drain words; the result for position p leaves with the
// word for position p+width+1. A drain word while no frame is in progress is dropped.
// Results leave on out_o with their row and column; last marks the final pixel, after
// which the next word starts a new frame. Interior pixels carry the signed kernel sum,
// border pixels and frames under 3 pixels in either direction carry the pixel unchanged.
// Throughput is one word per clock while out_o accepts: the line memories are read for a
// word at its accept edge and written back as it leaves the first stage, with forwarding
// when the next word reads the same entry. A result is registered as its freeing word
// leaves the second stage. When out_o stalls, at most two more result-bearing words are
// taken before in_i.ready drops; while the second stage is empty, fill words keep flowing.
// Configuration (kernel, width, height) goes through the cfg_* write port while idle;
// writing width or height restarts the frame. Reset clears the counters, the window and
// the pipeline; the line memories need no clearing pass, since no result reads an entry
// of a frame before that frame has written it.
module image_convolution_3x3_unit import icv_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  icv_in_if.sink                   in_i,
  icv_out_if.source                out_o
);

  `include "assert_macros.svh"

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int FW    = $clog2(MAX_WIDTH + 2);
  localparam int ROWW  = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWW   = (WW > CFG_DATA_BITS) ? WW : CFG_DATA_BITS;
  localparam int CHW   = (HW > CFG_DATA_BITS) ? HW : CFG_DATA_BITS;
  localparam int W_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
  localparam int H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

  // Configuration registers, sizes held already clamped to the legal range.
  icv_kernel_e kernel_q;
  logic [WW-1:0] w_eff_q;
  logic [HW-1:0] h_eff_q;
  logic [CWW-1:0] cfg_w_ext;
  logic [CHW-1:0] cfg_h_ext;
  logic [WW-1:0] w_cfg;
  logic [HW-1:0] h_cfg;
  logic cfg_restart;

  // Position counters on the input side.
  logic [COLW-1:0] in_col_q;
  logic [FW-1:0]   fill_q;
  logic [ROWW-1:0] out_row_q;
  logic [COLW-1:0] out_col_q;

  // Handshake and pipeline control.
  logic in_ready, in_fire, idle_drain, enter;
  logic primed, in_col_last, out_col_last, out_row_last, frame_last;
  logic [PIXEL_BITS-1:0] px_eff;
  logic [COLW+POS_BITS-1:0] row_pad, col_pad;
  icv_meta_t meta_d;

  logic                  s1_valid_q, s1_emit_q, s1_fwd_q;
  logic [COLW-1:0]       s1_col_q;
  logic [PIXEL_BITS-1:0] s1_px_q, fwd_top_q, fwd_mid_q;
  icv_meta_t             s1_meta_q;
  logic [PIXEL_BITS-1:0] rd_older, rd_recent, s1_top, s1_mid;
  logic                  s1_fire;

  logic      s2_valid_q, s2_free, s2_adv;
  icv_meta_t s2_meta_q;

  logic [PIXEL_BITS-1:0] win_q [3][3];

  logic out_valid_q, out_adv;
  logic signed [VALUE_BITS-1:0] out_value_q, mac_value;
  logic [POS_BITS-1:0] out_row_o_q, out_col_o_q;
  logic out_last_q;

  // ---------------------------------------------------------------- configuration
  assign cfg_w_ext = CWW'(cfg_data_i);
  assign cfg_h_ext = CHW'(cfg_data_i);

  // A size of zero acts as one; sizes beyond the maximum saturate.
  always_comb begin
    if (cfg_w_ext == '0) begin
      w_cfg = WW'(1);
    end else if (cfg_w_ext > CWW'(MAX_WIDTH)) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = cfg_w_ext[WW-1:0];
    end
    if (cfg_h_ext == '0) begin
      h_cfg = HW'(1);
    end else if (cfg_h_ext > CHW'(MAX_HEIGHT)) begin
      h_cfg = HW'(MAX_HEIGHT);
    end else begin
      h_cfg = cfg_h_ext[HW-1:0];
    end
  end

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      unique case (icv_cfg_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_restart = 1'b1;
        CFG_HEIGHT: cfg_restart = 1'b1;
        default:    cfg_restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= K_EMBOSS;
      w_eff_q  <= WW'(W_RST);
      h_eff_q  <= HW'(H_RST);
    end else if (cfg_we_i) begin
      unique case (icv_cfg_e'(cfg_idx_i))
        CFG_KERNEL: kernel_q <= icv_kernel_e'(cfg_data_i[1:0]);
        CFG_WIDTH:  w_eff_q  <= w_cfg;
        CFG_HEIGHT: h_eff_q  <= h_cfg;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  // A word is taken whenever the first stage is empty or moving on this cycle.
  assign in_ready   = !s1_valid_q || s1_fire;
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  // With the fill count at zero no frame is in progress, so a drain word is dropped.
  assign idle_drain = in_i.mode && (fill_q == '0);
  assign enter      = in_fire && !idle_drain;
  assign px_eff     = in_i.mode ? '0 : in_i.pixel;

  // Once width+1 positions have gone in, every further word releases one result.
  assign primed       = fill_q == (FW'(w_eff_q) + FW'(1));
  assign in_col_last  = WW'(in_col_q) == (w_eff_q - WW'(1));
  assign out_col_last = WW'(out_col_q) == (w_eff_q - WW'(1));
  assign out_row_last = HW'(out_row_q) == (h_eff_q - HW'(1));
  assign frame_last   = primed && out_col_last && out_row_last;

  assign row_pad = {{(COLW + POS_BITS - ROWW){1'b0}}, out_row_q};
  assign col_pad = {{POS_BITS{1'b0}}, out_col_q};

  always_comb begin
    meta_d.row      = row_pad[POS_BITS-1:0];
    meta_d.col      = col_pad[POS_BITS-1:0];
    meta_d.last     = frame_last;
    // Interior needs a neighbor on every side, which also rules out small frames.
    meta_d.interior = (out_row_q != '0) && ((HW'(out_row_q) + HW'(1)) < h_eff_q) &&
                      (out_col_q != '0) && ((WW'(out_col_q) + WW'(1)) < w_eff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      fill_q    <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_restart) begin
      in_col_q  <= '0;
      fill_q    <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (enter) begin
      if (frame_last) begin
        in_col_q  <= '0;
        fill_q    <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        in_col_q <= in_col_last ? '0 : in_col_q + COLW'(1);
        if (!primed) begin
          fill_q <= fill_q + FW'(1);
        end else begin
          out_col_q <= out_col_last ? '0 : out_col_q + COLW'(1);
          if (out_col_last) begin
            out_row_q <= out_row_q + ROWW'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- line memories
  // The read for a word is issued at its accept edge; its write-back follows when the
  // word leaves the first stage.
  icv_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (enter),
    .rd_addr_i   (in_col_q),
    .wr_en_i     (s1_fire),
    .wr_addr_i   (s1_col_q),
    .wr_older_i  (s1_mid),
    .wr_recent_i (s1_px_q),
    .rd_older_o  (rd_older),
    .rd_recent_o (rd_recent)
  );

  // When the word in the first stage writes the entry that the new word reads at the
  // same edge, the memory returns stale data, so the written values are kept aside.
  assign s1_top = s1_fwd_q ? fwd_top_q : rd_older;
  assign s1_mid = s1_fwd_q ? fwd_mid_q : rd_recent;

  // ---------------------------------------------------------------- first stage
  // The window may only shift once the word in the second stage has used it.
  assign s2_free = !s2_valid_q || out_adv;
  assign s1_fire = s1_valid_q && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= enter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enter) begin
      s1_col_q  <= in_col_q;
      s1_px_q   <= px_eff;
      s1_emit_q <= primed;
      s1_meta_q <= meta_d;
      s1_fwd_q  <= s1_fire && (s1_col_q == in_col_q);
      fwd_top_q <= s1_mid;
      fwd_mid_q <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= s1_top;
      win_q[1][2] <= s1_mid;
      win_q[2][2] <= s1_px_q;
    end
  end

  // ---------------------------------------------------------------- second stage
  // The window register is the operand of the word held here.
  assign s2_adv = s2_valid_q && out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  icv_kernel_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel_mac (
    .win_i      (win_q),
    .kernel_i   (kernel_q),
    .interior_i (s2_meta_q.interior),
    .value_o    (mac_value)
  );

  // ---------------------------------------------------------------- output register
  assign out_adv = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_value_q <= mac_value;
      out_row_o_q <= s2_meta_q.row;
      out_col_o_q <= s2_meta_q.col;
      out_last_q  <= s2_meta_q.last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.value   = out_value_q;
  assign out_o.out_row = out_row_o_q;
  assign out_o.out_col = out_col_o_q;
  assign out_o.last    = out_last_q;

  // ---------------------------------------------------------------- assertions
  `ICV_ASSERT(a_in_col_range, clk_i, rst_ni, WW'(in_col_q) < w_eff_q, "input column beyond width")
  `ICV_ASSERT(a_fill_range, clk_i, rst_ni, fill_q <= (FW'(w_eff_q) + FW'(1)), "fill overrun")
  `ICV_ASSERT(a_out_col_range, clk_i, rst_ni, WW'(out_col_q) < w_eff_q, "output column overrun")
  `ICV_ASSERT(a_out_row_range, clk_i, rst_ni, HW'(out_row_q) < h_eff_q, "output row overrun")
  `ICV_ASSERT(a_window_held, clk_i, rst_ni, s2_valid_q && !out_adv |-> !s1_fire, "window moved")

endmodule
